FILE: hdl/assert_macros.svh
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/psu_pkg.sv
package psu_pkg;

  localparam int unsigned FRAME_SAMPLES = 307200;

  localparam int BYTE_W   = 8;
  localparam int STORE_W  = 24;
  localparam int HELD_W   = 5;
  localparam int WIDTH_W  = 5;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 19;

  localparam logic [WIDTH_W-1:0] WIDTH_RST = 5'd11;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN = 5'd8;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 5'd16;
  localparam logic [HELD_W-1:0]  HELD_CAP  = 5'd24;
  localparam logic [CNT_W-1:0]   FRAME_LAST = CNT_W'(FRAME_SAMPLES);

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              frame_start;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } out_word_t;

  // One pending extraction: accumulator snapshot, bit offset, width and frame-end flag.
  typedef struct packed {
    logic [STORE_W-1:0] store;
    logic [HELD_W-1:0]  shift;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } cmd_t;

  // Saturate the configured width into 8..16.
  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] r;
    if (w < WIDTH_MIN) begin
      r = WIDTH_MIN;
    end else if (w > WIDTH_MAX) begin
      r = WIDTH_MAX;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

FILE: hdl/psu_front.sv
module psu_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [psu_pkg::WIDTH_W-1:0]     cfg_wr_data,
  input  logic                            accept,
  input  psu_pkg::in_word_t               in_word,
  output logic                            cmd_push,
  output psu_pkg::cmd_t                   cmd
);

  logic [psu_pkg::WIDTH_W-1:0] width_r;
  logic [psu_pkg::STORE_W-1:0] store_r, store_nxt, store_base;
  logic [psu_pkg::HELD_W-1:0]  held_r, held_nxt, held_base, held_sum, held_left;
  logic [psu_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, cnt_base, cnt_inc;
  logic [psu_pkg::HELD_W:0]    sum_wide;
  logic [psu_pkg::WIDTH_W-1:0] w;
  logic                        emit, last;

  always_comb begin
    w          = psu_pkg::eff_width(width_r);
    store_base = in_word.frame_start ? '0 : store_r;
    held_base  = in_word.frame_start ? '0 : held_r;
    cnt_base   = in_word.frame_start ? '0 : cnt_r;
    store_nxt  = {store_base[psu_pkg::STORE_W-psu_pkg::BYTE_W-1:0], in_word.byte_in};
    sum_wide   = {1'b0, held_base} + (psu_pkg::HELD_W+1)'(psu_pkg::BYTE_W);
    held_sum   = (sum_wide > {1'b0, psu_pkg::HELD_CAP}) ? psu_pkg::HELD_CAP
                                                       : sum_wide[psu_pkg::HELD_W-1:0];
    emit       = (held_sum >= w);
    held_left  = held_sum - w;
    cnt_inc    = cnt_base + 1'b1;
    last       = (cnt_inc >= psu_pkg::FRAME_LAST);
    held_nxt   = emit ? held_left : held_sum;
    cnt_nxt    = emit ? (last ? '0 : cnt_inc) : cnt_base;
  end

  assign cmd_push  = accept && emit;
  assign cmd.store = store_nxt;
  assign cmd.shift = held_left;
  assign cmd.width = w;
  assign cmd.last  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= psu_pkg::WIDTH_RST;
      store_r <= '0;
      held_r  <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      if (accept) begin
        store_r <= store_nxt;
        held_r  <= held_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

`include "assert_macros.svh"

  `PSU_ASSERT_NOW(a_held_below_width, 1'b1, held_r < psu_pkg::WIDTH_MAX, "leftover bits reach a full sample")
  `PSU_ASSERT_NOW(a_cnt_in_frame, 1'b1, cnt_r < psu_pkg::FRAME_LAST, "sample counter past frame size")

endmodule

FILE: hdl/psu_cmd_q.sv
module psu_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  psu_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output psu_pkg::cmd_t cmd_out,
  output logic          empty
);

  psu_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

`include "assert_macros.svh"

  `PSU_ASSERT_NXT(a_push_grows, do_push && !do_pop, count_r == $past(count_r) + 2'd1, "queue count missed a push")

endmodule

FILE: hdl/psu_back.sv
module psu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  psu_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output psu_pkg::out_word_t out_word
);

  psu_pkg::out_word_t          slot_r [2];
  psu_pkg::out_word_t          res;
  logic [psu_pkg::STORE_W-1:0] shifted;
  logic [psu_pkg::SAMPLE_W-1:0] mask;
  logic                        wr_ptr_r, rd_ptr_r;
  logic [1:0]                  count_r;
  logic                        do_pop;

  assign empty    = (count_r == 2'd0);
  assign do_pop   = pop && !empty;
  assign cmd_pop  = !cmd_empty && (count_r != 2'd2);
  assign out_word = slot_r[rd_ptr_r];

  // Extract the oldest 'width' valid bits, sitting just above 'shift'.
  always_comb begin
    shifted       = cmd.store >> cmd.shift;
    mask          = {psu_pkg::SAMPLE_W{1'b1}} >> (psu_pkg::WIDTH_MAX - cmd.width);
    res.sample    = shifted[psu_pkg::SAMPLE_W-1:0] & mask;
    res.frame_end = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (cmd_pop) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({cmd_pop, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

`include "assert_macros.svh"

  `PSU_ASSERT_NXT(a_fill_shows, cmd_pop, !empty, "extracted sample not visible")

endmodule

FILE: hdl/packed_sample_unpacker.sv
// Packed sample unpacker: one byte per cycle in unless full, at most one sample per byte out.
// Each sample is registered in the command queue, then in the result queue feeding the ports.
// Throughput: 1 byte per cycle unless full; the 2-word command queue and 2-word result
// queue absorb short stalls on either side.
// Reset (rst_n low, synchronous): queues emptied, accumulator and frame counter cleared,
// sample width back to 11.
module packed_sample_unpacker (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [psu_pkg::WIDTH_W-1:0] cfg_wr_data,
  // byte side
  input  logic                        push,
  output logic                        full,
  input  psu_pkg::in_word_t           in_word,
  // sample side
  output logic                        empty,
  input  logic                        pop,
  output psu_pkg::out_word_t          out_word
);

  // Front -> queue -> back.
  psu_pkg::cmd_t cmd_w, cmd_q;
  logic          cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic          accept;

  // Bytes are refused only when the command queue is full; bytes that
  // complete no sample still need a slot-free check, which keeps the
  // front simple and costs nothing at steady rate.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Front: holds the bit accumulator, leftover count and frame counter,
  // decides per byte whether a sample completes.
  psu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_word     (in_word),
    .cmd_push    (cmd_push),
    .cmd         (cmd_w)
  );

  // Decoupling queue between classification and extraction.
  psu_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .cmd_in  (cmd_w),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .cmd_out (cmd_q),
    .empty   (cmd_empty)
  );

  // Back: shift-and-mask extraction into the registered result queue.
  psu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_q),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_word  (out_word)
  );

endmodule

FILE: dv/psu_sample_checker.sv
module psu_sample_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [psu_pkg::WIDTH_W-1:0] cfg_wr_data,
  input  logic                        push,
  input  logic                        full,
  input  psu_pkg::in_word_t           in_word,
  input  logic                        empty,
  input  logic                        pop,
  input  psu_pkg::out_word_t          out_word,
  output int                          fail_count,
  output int                          words_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  // Shadow of the block's state.
  logic [psu_pkg::WIDTH_W-1:0] width_reg;
  logic [psu_pkg::STORE_W-1:0] acc_bits;
  logic [psu_pkg::HELD_W-1:0]  acc_count;
  logic [psu_pkg::CNT_W-1:0]   frame_count;

  psu_pkg::out_word_t sample_q[$];
  int                 n_fail = 0;

  // Shift one byte into the accumulator; queue a sample once enough bits are held.
  function automatic void unpack_byte(input psu_pkg::in_word_t w);
    logic [psu_pkg::WIDTH_W-1:0] wid;
    logic [31:0]                 mask;
    psu_pkg::out_word_t          res;
    wid = width_reg;
    if (wid < psu_pkg::WIDTH_MIN) begin
      wid = psu_pkg::WIDTH_MIN;
    end else if (wid > psu_pkg::WIDTH_MAX) begin
      wid = psu_pkg::WIDTH_MAX;
    end
    if (w.frame_start) begin
      acc_bits    = '0;
      acc_count   = '0;
      frame_count = '0;
    end
    acc_bits  = {acc_bits[psu_pkg::STORE_W-psu_pkg::BYTE_W-1:0], w.byte_in};
    // at most 15 + 8 bits held, so no cap is needed
    acc_count = acc_count + psu_pkg::HELD_W'(psu_pkg::BYTE_W);
    if (acc_count >= wid) begin
      acc_count     = acc_count - wid;
      mask          = (32'd1 << wid) - 32'd1;
      res.sample    = psu_pkg::SAMPLE_W'((32'(acc_bits) >> acc_count) & mask);
      frame_count   = frame_count + 1'b1;
      res.frame_end = (32'(frame_count) >= psu_pkg::FRAME_SAMPLES);
      if (res.frame_end) begin
        frame_count = '0;
      end
      sample_q.insert(sample_q.size(), res);
    end
  endfunction

  always @(posedge clk) begin
    psu_pkg::out_word_t exp_w;
    if (!rst_n) begin
      width_reg   = psu_pkg::WIDTH_RST;
      acc_bits    = '0;
      acc_count   = '0;
      frame_count = '0;
      sample_q.delete();
    end else begin
      if (pop && !empty) begin
        if (sample_q.size() == 0) begin
          if (n_fail < REPORT_MAX) begin
            $display("%0t: unexpected word sample=%h frame_end=%b", $time,
                     out_word.sample, out_word.frame_end);
          end
          n_fail++;
        end else begin
          exp_w = sample_q.pop_front();
          if (out_word.sample !== exp_w.sample ||
              out_word.frame_end !== exp_w.frame_end) begin
            if (n_fail < REPORT_MAX) begin
              $display("%0t: mismatch sample exp %h got %h, frame_end exp %b got %b",
                       $time, exp_w.sample, out_word.sample,
                       exp_w.frame_end, out_word.frame_end);
            end
            n_fail++;
          end
        end
      end
      // a byte taken at this edge uses the width held before any write at the same edge
      if (push && !full) begin
        unpack_byte(in_word);
      end
      if (cfg_wr_en) begin
        width_reg = cfg_wr_data;
      end
    end
    fail_count <= n_fail;
    words_owed <= sample_q.size();
  end

endmodule

FILE: dv/packed_sample_unpacker_tb.sv
module packed_sample_unpacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 10;
  localparam int RST_CYCLES   = 12;
  // the completing byte passes the command and result queues first; allow a good margin
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 50_000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 80;

  localparam logic [psu_pkg::WIDTH_W-1:0] W_INFRARED = 5'd10;
  localparam logic [psu_pkg::WIDTH_W-1:0] W_DEPTH    = 5'd11;

  logic                        clk;
  logic                        rst_n       = 1'b0;
  logic                        cfg_wr_en   = 1'b0;
  logic [psu_pkg::WIDTH_W-1:0] cfg_wr_data = '0;
  logic                        push        = 1'b0;
  logic                        full;
  psu_pkg::in_word_t           in_word     = '0;
  logic                        empty;
  logic                        pop         = 1'b0;
  psu_pkg::out_word_t          out_word;

  int fail_count;
  int words_owed;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  packed_sample_unpacker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .in_word    (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word   (out_word)
  );

  psu_sample_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .in_word    (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word   (out_word),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Sample side: pop is re-rolled every cycle against the current stall rate.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL packed_sample_unpacker");
    $finish;
  end

  // Offer one byte word and hold it until the block takes it. push stays high
  // between back-to-back words; it only drops during an idle gap.
  task automatic put_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    in_word.byte_in     <= b;
    in_word.frame_start <= start;
    push                <= 1'b1;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted sample has come out, then let
  // the pipeline settle so that bytes yielding no sample are finished too.
  task automatic drain_samples();
    push <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only ever called with the block drained.
  task automatic write_width(input logic [psu_pkg::WIDTH_W-1:0] w);
    cfg_wr_data <= w;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Idling modes: none, sender gaps, receiver stalls, both.
  task automatic set_mode(input int m);
    case (m)
      0: begin
        send_idle_pct = 0;
        stall_pct    <= 0;
      end
      1: begin
        send_idle_pct = 47;
        stall_pct    <= 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct    <= 47;
      end
      default: begin
        send_idle_pct = 28;
        stall_pct    <= 28;
      end
    endcase
  endtask

  initial begin
    logic [psu_pkg::WIDTH_W-1:0] w;
    logic                        start;

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Reset width (11): all ones, all zeros, alternating bits,
    // then a frame start arriving with bits still held.
    put_byte(8'hFF, 1'b1);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hAA, 1'b0);
    put_byte(8'h55, 1'b1);
    put_byte(8'h0F, 1'b0);
    // Widest samples; the bits left over from width 11 are read at width 16.
    drain_samples();
    write_width(psu_pkg::WIDTH_MAX);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    // Register value zero saturates to 8.
    drain_samples();
    write_width('0);
    put_byte(8'h81, 1'b0);
    put_byte(8'h7E, 1'b1);
    // All ones in the register saturates to 16.
    drain_samples();
    write_width('1);
    put_byte(8'hFF, 1'b1);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    // Just outside the legal range on either side.
    drain_samples();
    write_width(5'd7);
    put_byte(8'h01, 1'b0);
    put_byte(8'h80, 1'b0);
    drain_samples();
    write_width(5'd17);
    put_byte(8'hC3, 1'b1);
    put_byte(8'h3C, 1'b0);

    // Random part: one width per phase, idling modes in rotation. Odd phases
    // carry on mid-stream so held bits are reinterpreted at the new width.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       w = W_INFRARED;
        1:       w = psu_pkg::WIDTH_MIN;
        2:       w = psu_pkg::WIDTH_MAX;
        3:       w = 5'd13;
        4:       w = 5'd9;
        5:       w = 5'd14;
        6:       w = 5'd12;
        7:       w = 5'd15;
        8:       w = W_DEPTH;
        default: w = 5'd3;
      endcase
      drain_samples();
      write_width(w);
      set_mode(p % 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        start = ((i == 0) && (p % 2 == 0)) || ($urandom_range(63) == 0);
        put_byte(8'($urandom_range(255)), start);
        // sender holds off mid-phase until the sample side has caught up
        if (i == PHASE_ITEMS / 2 && p % 3 == 1) begin
          drain_samples();
        end
      end
    end

    drain_samples();
    if (fail_count == 0 && words_owed == 0) begin
      $display("PASS packed_sample_unpacker");
    end else begin
      $display("FAIL packed_sample_unpacker");
    end
    $finish;
  end

endmodule
